### rtl/core/pfde_pkg.sv
package pfde_pkg;

  localparam int Size = 5;
  localparam int LetterW = 5;
  localparam int IdxW = 3;
  localparam int NumRegs = Size;
  localparam int RegIdxW = 3;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef logic [LetterW-1:0] letter_t;
  typedef letter_t [Size-1:0] key_row_t;
  typedef key_row_t [Size-1:0] key_sq_t;
  typedef logic [IdxW-1:0] sq_idx_t;

  localparam letter_t CodeI = 5'd8;
  localparam letter_t CodeJ = 5'd9;
  localparam letter_t CodeX = 5'd23;

  localparam key_row_t KeyRow0Rst = 25'd10755244;
  localparam key_row_t KeyRow1Rst = 25'd17283508;
  localparam key_row_t KeyRow2Rst = 25'd25942713;
  localparam key_row_t KeyRow3Rst = 25'd6848868;
  localparam key_row_t KeyRow4Rst = 25'd2149955;

  typedef struct packed {
    logic    found;
    sq_idx_t row;
    sq_idx_t col;
  } loc_t;

  // Finds the first matching cell in row-major order.
  function automatic loc_t locate(input key_sq_t sq, input letter_t ch);
    loc_t res;
    res = '0;
    for (int r = 0; r < Size; r++) begin
      for (int c = 0; c < Size; c++) begin
        if (!res.found && sq[r][c] == ch) begin
          res.found = 1'b1;
          res.row   = sq_idx_t'(r);
          res.col   = sq_idx_t'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic sq_idx_t wrap_inc(input sq_idx_t idx);
    sq_idx_t res;
    if (idx == sq_idx_t'(Size - 1)) begin
      res = '0;
    end else begin
      res = idx + sq_idx_t'(1);
    end
    return res;
  endfunction

endpackage

### rtl/core/playfair_digraph_encrypt_unit.sv
// Playfair digraph encryptor.
// Input channel: one plaintext letter per request (in_letter, in_end_of_message),
// accepted when in_valid is high and in_stall is low. Letters are paired into
// digraphs, with X as filler between equal letters of a pair and after an odd
// final letter; J is treated as I.
// Output channel: one enciphered digraph per request (out_cipher_first,
// out_cipher_second, out_letter_not_found, out_final_pair), taken when
// out_valid is high and out_stall is low.
// The key square lives in five APB registers, one row each at byte address 4*i.
// Throughput is one letter per cycle while in_stall is low. A digraph passes
// through the pair register and then the output register. When equal letters
// end a message, two digraphs are produced and the input stalls while the
// second one waits in the second pair register.
// When the receiver stalls, the output register holds its request and the pair
// register fills, after which in_stall rises.
// Reset empties both registers, drops any held letter and loads the default square.
module playfair_digraph_encrypt_unit
  import pfde_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [4:0]       in_letter,
  input  logic             in_end_of_message,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       out_cipher_first,
  output logic [4:0]       out_cipher_second,
  output logic             out_letter_not_found,
  output logic             out_final_pair,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  key_sq_t key_r;
  logic [RegIdxW-1:0] reg_idx;

  logic    held_valid_r, held_valid_nxt;
  letter_t held_letter_r, held_letter_nxt;

  logic    p_valid_r, p_valid_nxt;
  letter_t p_a_r, p_a_nxt;
  letter_t p_b_r, p_b_nxt;
  logic    p_fin_r, p_fin_nxt;
  logic    p2_valid_r, p2_valid_nxt;
  letter_t p2_a_r, p2_a_nxt;

  logic    o_valid_r;
  letter_t o_first_r, o_first_nxt;
  letter_t o_second_r, o_second_nxt;
  logic    o_nf_r, o_nf_nxt;
  logic    o_fin_r;

  logic    in_accept, out_load, p_move;
  letter_t l_in;
  loc_t    loc_a, loc_b;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    prdata = '0;
    if (reg_idx < RegIdxW'(NumRegs)) begin
      prdata = DataW'(key_r[reg_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= KeyRow0Rst;
      key_r[1] <= KeyRow1Rst;
      key_r[2] <= KeyRow2Rst;
      key_r[3] <= KeyRow3Rst;
      key_r[4] <= KeyRow4Rst;
    end else if (psel && penable && pwrite && reg_idx < RegIdxW'(NumRegs)) begin
      key_r[reg_idx] <= key_row_t'(pwdata[Size*LetterW-1:0]);
    end
  end

  assign out_load  = !o_valid_r || !out_stall;
  assign p_move    = p_valid_r && out_load;
  assign in_stall  = p2_valid_r || (p_valid_r && !out_load);
  assign in_accept = in_valid && !in_stall;
  assign l_in      = (in_letter == CodeJ) ? CodeI : in_letter;

  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    p_valid_nxt     = p_valid_r;
    p_a_nxt         = p_a_r;
    p_b_nxt         = p_b_r;
    p_fin_nxt       = p_fin_r;
    p2_valid_nxt    = p2_valid_r;
    p2_a_nxt        = p2_a_r;
    if (p_move) begin
      p_valid_nxt = p2_valid_r;
      p_a_nxt     = p2_a_r;
      p_b_nxt     = CodeX;
      p_fin_nxt   = 1'b1;
      p2_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      if (!held_valid_r) begin
        if (in_end_of_message) begin
          p_valid_nxt = 1'b1;
          p_a_nxt     = l_in;
          p_b_nxt     = CodeX;
          p_fin_nxt   = 1'b1;
        end else begin
          held_valid_nxt  = 1'b1;
          held_letter_nxt = l_in;
        end
      end else if (held_letter_r == l_in) begin
        p_valid_nxt = 1'b1;
        p_a_nxt     = held_letter_r;
        p_b_nxt     = CodeX;
        p_fin_nxt   = 1'b0;
        if (in_end_of_message) begin
          p2_valid_nxt    = 1'b1;
          p2_a_nxt        = l_in;
          held_valid_nxt  = 1'b0;
          held_letter_nxt = '0;
        end
      end else begin
        p_valid_nxt     = 1'b1;
        p_a_nxt         = held_letter_r;
        p_b_nxt         = l_in;
        p_fin_nxt       = in_end_of_message;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end
    end
  end

  always_comb begin
    loc_a        = locate(key_r, p_a_r);
    loc_b        = locate(key_r, p_b_r);
    o_first_nxt  = '0;
    o_second_nxt = '0;
    o_nf_nxt     = !(loc_a.found && loc_b.found);
    if (loc_a.found && loc_b.found) begin
      if (loc_a.row == loc_b.row) begin
        o_first_nxt  = key_r[loc_a.row][wrap_inc(loc_a.col)];
        o_second_nxt = key_r[loc_b.row][wrap_inc(loc_b.col)];
      end else if (loc_a.col == loc_b.col) begin
        o_first_nxt  = key_r[wrap_inc(loc_a.row)][loc_a.col];
        o_second_nxt = key_r[wrap_inc(loc_b.row)][loc_b.col];
      end else begin
        o_first_nxt  = key_r[loc_a.row][loc_b.col];
        o_second_nxt = key_r[loc_b.row][loc_a.col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      p_valid_r     <= 1'b0;
      p2_valid_r    <= 1'b0;
      o_valid_r     <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
      p_valid_r     <= p_valid_nxt;
      p2_valid_r    <= p2_valid_nxt;
      if (out_load) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_a_r   <= p_a_nxt;
    p_b_r   <= p_b_nxt;
    p_fin_r <= p_fin_nxt;
    p2_a_r  <= p2_a_nxt;
    if (p_move) begin
      o_first_r  <= o_first_nxt;
      o_second_r <= o_second_nxt;
      o_nf_r     <= o_nf_nxt;
      o_fin_r    <= p_fin_r;
    end
  end

  assign out_valid            = o_valid_r;
  assign out_cipher_first     = o_first_r;
  assign out_cipher_second    = o_second_r;
  assign out_letter_not_found = o_nf_r;
  assign out_final_pair       = o_fin_r;

endmodule
